// ===== hdl/trvg_pkg.sv =====
// Shared types, constants and helper functions of the trail ribbon vertex generator.
package trvg_pkg;

  localparam int TrailPointsDef = 128;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SHIFT  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] CFG_AGE_START   = 3'd0;
  localparam logic [2:0] CFG_AGE_DECAY   = 3'd1;
  localparam logic [2:0] CFG_WIDTH_CAP   = 3'd2;
  localparam logic [2:0] CFG_WIDE_GAIN   = 3'd3;
  localparam logic [2:0] CFG_NARROW_GAIN = 3'd4;

  localparam logic [11:0] AGE_START_RST   = 12'd3141;
  localparam logic [11:0] AGE_DECAY_RST   = 12'd20;
  localparam logic [30:0] WIDTH_CAP_RST   = 31'd6554;
  localparam logic [22:0] WIDE_GAIN_RST   = 23'd196608;
  localparam logic [22:0] NARROW_GAIN_RST = 23'd52429;
  localparam logic [31:0] LEN_GAIN        = 32'd26214;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic               wide_trail;
    logic [2:0]         player_key;
    logic signed [31:0] shift_x;
    logic [6:0]         slot;
  } trvg_in_t;

  typedef struct packed {
    logic               alive;
    logic [6:0]         start_slot;
    logic [6:0]         end_slot;
    logic [11:0]        age_left;
    logic [2:0]         owner_key;
    logic signed [31:0] left_x;
    logic signed [31:0] left_y;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
  } trvg_out_t;

  typedef struct packed {
    logic        start;
    logic        sqrt_mode;
    logic [63:0] operand;
    logic [31:0] divisor;
  } trvg_unit_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] result;
  } trvg_unit_rsp_t;

  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [63:0] rnd16(input logic [63:0] p);
    return (p + 64'd32768) >> 16;
  endfunction

endpackage

// ===== hdl/trvg_if.sv =====
// Handshake channel interfaces for input items, result items and register writes.
interface trvg_in_if import trvg_pkg::*; ();
  logic     valid;
  logic     ready;
  trvg_in_t data;
  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

interface trvg_out_if import trvg_pkg::*; ();
  logic      valid;
  logic      ready;
  trvg_out_t data;
  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

interface trvg_cfg_if import trvg_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport src (output valid, output index, output data, input ready);
  modport snk (input valid, input index, input data, output ready);
endinterface

// ===== hdl/trvg_iter_unit.sv =====
// Shared bit-serial unit for floor square root and unsigned division.
module trvg_iter_unit import trvg_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  trvg_unit_req_t req_i,
  output trvg_unit_rsp_t rsp_o
);

  logic        busy_q, done_q, sqrt_q;
  logic [5:0]  cnt_q;
  logic [34:0] rem_q, rem_n, trial, rem_d;
  logic [63:0] op_q;
  logic [47:0] acc_q;
  logic [31:0] div_q;
  logic        ge;

  always_comb begin
    if (sqrt_q) begin
      rem_n = {rem_q[32:0], op_q[63:62]};
      trial = {1'b0, acc_q[31:0], 2'b01};
    end else begin
      rem_n = {rem_q[33:0], op_q[63]};
      trial = {3'b000, div_q};
    end
    ge    = rem_n >= trial;
    rem_d = ge ? rem_n - trial : rem_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.sqrt_mode ? 6'd31 : 6'd47;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.sqrt_mode;
      rem_q  <= '0;
      acc_q  <= '0;
      div_q  <= req_i.divisor;
      op_q   <= req_i.sqrt_mode ? req_i.operand : {req_i.operand[47:0], 16'h0000};
    end else if (busy_q) begin
      rem_q <= rem_d;
      acc_q <= {acc_q[46:0], ge};
      op_q  <= sqrt_q ? {op_q[61:0], 2'b00} : {op_q[62:0], 1'b0};
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("unit started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("unit done while busy");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == '0 && !req_i.start) |=> done_q) else $error("unit done missing");
`endif

endmodule

// ===== hdl/trail_ribbon_vertex_generator_core.sv =====
// Top level: trail ring storage, sequencer and ribbon vertex datapath.
// One item at a time; ready is high only while idle.
// Shift reads and rewrites the x coordinate of every ring slot in turn while the trail is live.
// A read of an inner slot runs three 32-step square roots and, unless the normal is zero,
// two 48-step divisions on the shared bit-serial unit; end, empty or invalid slots skip the unit.
// Reset clears the trail at once through per-slot valid bits and loads register defaults.
module trail_ribbon_vertex_generator_core import trvg_pkg::*; #(
  parameter int TRAIL_POINTS = TrailPointsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  trvg_cfg_if.snk    cfg_i,
  trvg_in_if.snk     in_i,
  trvg_out_if.src    out_o
);

  localparam int AW = $clog2(TRAIL_POINTS);
  localparam int SW = (AW > 7) ? AW : 7;
  localparam logic [AW-1:0] LAST = AW'(TRAIL_POINTS - 1);

  localparam logic [5:0] S_IDLE = 6'd0,  S_AP1 = 6'd1,  S_AP2 = 6'd2,  S_TICK = 6'd3;
  localparam logic [5:0] S_SHRD = 6'd4,  S_SHWR = 6'd5, S_RD0 = 6'd6,  S_RDP = 6'd7;
  localparam logic [5:0] S_RDPV = 6'd8,  S_RDNX = 6'd9, S_M1 = 6'd10,  S_M2 = 6'd11;
  localparam logic [5:0] S_M3 = 6'd12,   S_W1 = 6'd13,  S_M4 = 6'd14,  S_M5 = 6'd15;
  localparam logic [5:0] S_M6 = 6'd16,   S_W2 = 6'd17,  S_M7 = 6'd18,  S_M8 = 6'd19;
  localparam logic [5:0] S_M9 = 6'd20,   S_M10 = 6'd21, S_M11 = 6'd22, S_M12 = 6'd23;
  localparam logic [5:0] S_M13 = 6'd24,  S_W3 = 6'd25,  S_M14 = 6'd26, S_W4 = 6'd27;
  localparam logic [5:0] S_M15 = 6'd28,  S_M16 = 6'd29, S_W5 = 6'd30,  S_M17 = 6'd31;
  localparam logic [5:0] S_M18 = 6'd32,  S_FIN = 6'd33, S_DONE = 6'd34;

  logic [5:0]  state_q, state_d;
  logic [11:0] age_start_q, age_decay_q;
  logic [30:0] width_cap_q;
  logic [22:0] wide_gain_q, narrow_gain_q;

  logic                    live_q, live_d;
  logic [AW-1:0]           head_q, head_d, tail_q, tail_d, idx_q, idx_d;
  logic [11:0]             age_q, age_d;
  logic [22:0]             gain_q, gain_d;
  logic [2:0]              owner_q, owner_d;
  logic [TRAIL_POINTS-1:0] valid_x_q, valid_x_d, valid_y_q, valid_y_d;
  logic                    out_valid_q, out_valid_d;

  logic signed [31:0] mem_x [TRAIL_POINTS];
  logic signed [31:0] mem_y [TRAIL_POINTS];
  logic signed [31:0] rd_x_q, rd_y_q, rdx, rdy, wr_x, wr_y;
  logic               rd_vx_q, rd_vy_q, wr_x_en, wr_y_en;
  logic [AW-1:0]      rd_addr, wr_addr;

  trvg_in_t           in_q;
  trvg_out_t          out_q;
  logic               in_acc, out_load;
  logic signed [31:0] px_q, py_q, v1x_q, v1y_q, v2x_q, v2y_q;
  logic signed [31:0] lx_q, ly_q, rvx_q, rvy_q;
  logic [63:0]        p_q, sq_q, wfull;
  logic [32:0]        ma, sum_q, t_q, ox_q, oy_q;
  logic [31:0]        mb, norm_q;
  logic [64:0]        prod;
  logic [30:0]        width_q, ua_q, ub_q, ua_s, ub_s;
  logic [16:0]        ux_q;
  logic               a_neg_q, b_neg_q;
  logic signed [34:0] a_v, b_v, sox, soy;
  logic [33:0]        ua_f, ub_f, m_f;

  logic [SW-1:0]      slot_w;
  logic [AW-1:0]      slot_idx, prev_idx, next_idx, len, pos, head_inc;
  logic               slot_bad, endpt;

  trvg_unit_req_t unit_req;
  trvg_unit_rsp_t unit_rsp;

  trvg_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .rsp_o  (unit_rsp)
  );

  function automatic logic [AW-1:0] span(input logic [AW-1:0] hi, input logic [AW-1:0] lo);
    logic [AW:0] d;
    d = {1'b0, hi} - {1'b0, lo};
    if (hi < lo) begin
      d = d + (AW+1)'(TRAIL_POINTS);
    end
    return d[AW-1:0];
  endfunction

  assign in_acc       = in_i.valid && in_i.ready;
  assign in_i.ready   = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid  = out_valid_q;
  assign out_o.data   = out_q;
  assign out_load     = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign rdx = rd_vx_q ? rd_x_q : 32'sd0;
  assign rdy = rd_vy_q ? rd_y_q : 32'sd0;

  assign slot_w   = SW'(in_q.slot);
  assign slot_idx = slot_w[AW-1:0];
  assign prev_idx = (slot_idx == '0) ? LAST : slot_idx - AW'(1);
  assign next_idx = (slot_idx == LAST) ? '0 : slot_idx + AW'(1);
  assign head_inc = (head_q == LAST) ? '0 : head_q + AW'(1);
  assign len      = span(head_q, tail_q);
  assign pos      = span(slot_idx, tail_q);
  assign slot_bad = !live_q || (32'(in_q.slot) >= 32'(TRAIL_POINTS)) || (len == '0)
                    || (pos > len);
  assign endpt    = (pos == '0) || (pos == len);

  assign a_v  = (35'(v1y_q) <<< 1) + 35'(v2y_q);
  assign b_v  = -((35'(v1x_q) <<< 1) + 35'(v2x_q));
  assign ua_f = a_v[34] ? 34'(-a_v) : 34'(a_v);
  assign ub_f = b_v[34] ? 34'(-b_v) : 34'(b_v);
  assign m_f  = ua_f | ub_f;
  assign ua_s = m_f[32] ? 31'(ua_f >> 2) : (m_f[31] ? 31'(ua_f >> 1) : 31'(ua_f));
  assign ub_s = m_f[32] ? 31'(ub_f >> 2) : (m_f[31] ? 31'(ub_f >> 1) : 31'(ub_f));
  assign wfull = rnd16(p_q);
  assign sox  = a_neg_q ? -$signed({2'b00, ox_q}) : $signed({2'b00, ox_q});
  assign soy  = b_neg_q ? -$signed({2'b00, oy_q}) : $signed({2'b00, oy_q});

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_M1:    begin ma = 33'(mag32(v1x_q)); mb = mag32(v1x_q); end
      S_M2:    begin ma = 33'(mag32(v1y_q)); mb = mag32(v1y_q); end
      S_M4:    begin ma = 33'(mag32(v2x_q)); mb = mag32(v2x_q); end
      S_M5:    begin ma = 33'(mag32(v2y_q)); mb = mag32(v2y_q); end
      S_M7:    begin ma = sum_q; mb = LEN_GAIN; end
      S_M9:    begin ma = t_q; mb = 32'(gain_q); end
      S_M11:   begin ma = 33'(ua_q); mb = 32'(ua_q); end
      S_M12:   begin ma = 33'(ub_q); mb = 32'(ub_q); end
      S_M15,
      S_M17:   begin ma = 33'(ux_q); mb = 32'(width_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod = 65'(ma) * 65'(mb);

  always_comb begin
    state_d     = state_q;
    live_d      = live_q;
    head_d      = head_q;
    tail_d      = tail_q;
    idx_d       = idx_q;
    age_d       = age_q;
    gain_d      = gain_q;
    owner_d     = owner_q;
    valid_x_d   = valid_x_q;
    valid_y_d   = valid_y_q;
    out_valid_d = out_valid_q && !out_o.ready;
    rd_addr     = slot_idx;
    wr_addr     = head_inc;
    wr_x        = sat35(35'(in_q.pos_x) - 35'(in_q.offset_x));
    wr_y        = sat35(35'(in_q.pos_y) - 35'(in_q.offset_y));
    wr_x_en     = 1'b0;
    wr_y_en     = 1'b0;
    unit_req    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.data.op)
            OP_APPEND: state_d = S_AP1;
            OP_TICK:   state_d = S_TICK;
            OP_SHIFT:  begin state_d = live_q ? S_SHRD : S_DONE; idx_d = '0; end
            OP_READ:   state_d = S_RD0;
          endcase
        end
      end
      S_AP1: begin
        if (!live_q) begin
          valid_x_d    = '0;
          valid_y_d    = '0;
          valid_x_d[0] = 1'b1;
          valid_y_d[0] = 1'b1;
          wr_addr      = '0;
          wr_x         = in_q.pos_x;
          wr_y         = in_q.pos_y;
          wr_x_en      = 1'b1;
          wr_y_en      = 1'b1;
          owner_d      = in_q.player_key;
        end
        state_d = S_AP2;
      end
      S_AP2: begin
        live_d = 1'b1;
        head_d = head_inc;
        if (tail_q == head_inc) begin
          tail_d = (tail_q == LAST) ? '0 : tail_q + AW'(1);
        end
        wr_x_en             = 1'b1;
        wr_y_en             = 1'b1;
        valid_x_d[head_inc] = 1'b1;
        valid_y_d[head_inc] = 1'b1;
        age_d               = age_start_q;
        gain_d              = in_q.wide_trail ? wide_gain_q : narrow_gain_q;
        state_d             = S_DONE;
      end
      S_TICK: begin
        if (live_q) begin
          if (age_q < age_decay_q) begin
            live_d    = 1'b0;
            head_d    = '0;
            tail_d    = '0;
            age_d     = '0;
            gain_d    = '0;
            owner_d   = '0;
            valid_x_d = '0;
            valid_y_d = '0;
          end else begin
            age_d = age_q - age_decay_q;
          end
        end
        state_d = S_DONE;
      end
      S_SHRD: begin
        rd_addr = idx_q;
        state_d = S_SHWR;
      end
      S_SHWR: begin
        wr_addr          = idx_q;
        wr_x             = sat35(35'(rdx) + 35'(in_q.shift_x));
        wr_x_en          = 1'b1;
        valid_x_d[idx_q] = 1'b1;
        if (idx_q == LAST) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_SHRD;
        end
      end
      S_RD0:  state_d = slot_bad ? S_DONE : S_RDP;
      S_RDP: begin
        rd_addr = prev_idx;
        state_d = endpt ? S_DONE : S_RDPV;
      end
      S_RDPV: begin
        rd_addr = next_idx;
        state_d = S_RDNX;
      end
      S_RDNX: state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3: begin
        unit_req.start     = 1'b1;
        unit_req.sqrt_mode = 1'b1;
        unit_req.operand   = sq_q + p_q;
        state_d            = S_W1;
      end
      S_W1:   if (unit_rsp.done) state_d = S_M4;
      S_M4:   state_d = S_M5;
      S_M5:   state_d = S_M6;
      S_M6: begin
        unit_req.start     = 1'b1;
        unit_req.sqrt_mode = 1'b1;
        unit_req.operand   = sq_q + p_q;
        state_d            = S_W2;
      end
      S_W2:   if (unit_rsp.done) state_d = S_M7;
      S_M7:   state_d = S_M8;
      S_M8:   state_d = S_M9;
      S_M9:   state_d = S_M10;
      S_M10:  state_d = S_M11;
      S_M11:  state_d = S_M12;
      S_M12:  state_d = S_M13;
      S_M13: begin
        unit_req.start     = 1'b1;
        unit_req.sqrt_mode = 1'b1;
        unit_req.operand   = sq_q + p_q;
        state_d            = S_W3;
      end
      S_W3: begin
        if (unit_rsp.done) begin
          state_d = (unit_rsp.result[31:0] == '0) ? S_FIN : S_M14;
        end
      end
      S_M14: begin
        unit_req.start   = 1'b1;
        unit_req.operand = 64'({ua_q, 16'h0000}) + 64'(norm_q >> 1);
        unit_req.divisor = norm_q;
        state_d          = S_W4;
      end
      S_W4:   if (unit_rsp.done) state_d = S_M15;
      S_M15:  state_d = S_M16;
      S_M16: begin
        unit_req.start   = 1'b1;
        unit_req.operand = 64'({ub_q, 16'h0000}) + 64'(norm_q >> 1);
        unit_req.divisor = norm_q;
        state_d          = S_W5;
      end
      S_W5:   if (unit_rsp.done) state_d = S_M17;
      S_M17:  state_d = S_M18;
      S_M18:  state_d = S_FIN;
      S_FIN:  state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      live_q        <= 1'b0;
      head_q        <= '0;
      tail_q        <= '0;
      idx_q         <= '0;
      age_q         <= '0;
      gain_q        <= '0;
      owner_q       <= '0;
      valid_x_q     <= '0;
      valid_y_q     <= '0;
      out_valid_q   <= 1'b0;
      age_start_q   <= AGE_START_RST;
      age_decay_q   <= AGE_DECAY_RST;
      width_cap_q   <= WIDTH_CAP_RST;
      wide_gain_q   <= WIDE_GAIN_RST;
      narrow_gain_q <= NARROW_GAIN_RST;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      idx_q       <= idx_d;
      age_q       <= age_d;
      gain_q      <= gain_d;
      owner_q     <= owner_d;
      valid_x_q   <= valid_x_d;
      valid_y_q   <= valid_y_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_AGE_START:   age_start_q   <= cfg_i.data[11:0];
          CFG_AGE_DECAY:   age_decay_q   <= cfg_i.data[11:0];
          CFG_WIDTH_CAP:   width_cap_q   <= cfg_i.data[30:0];
          CFG_WIDE_GAIN:   wide_gain_q   <= cfg_i.data[22:0];
          CFG_NARROW_GAIN: narrow_gain_q <= cfg_i.data[22:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_x_en) mem_x[wr_addr] <= wr_x;
    if (wr_y_en) mem_y[wr_addr] <= wr_y;
    rd_x_q  <= mem_x[rd_addr];
    rd_y_q  <= mem_y[rd_addr];
    rd_vx_q <= valid_x_q[rd_addr];
    rd_vy_q <= valid_y_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod[63:0];
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          in_q  <= in_i.data;
          lx_q  <= '0;
          ly_q  <= '0;
          rvx_q <= '0;
          rvy_q <= '0;
        end
      end
      S_RDP: begin
        px_q <= rdx;
        py_q <= rdy;
        if (endpt) begin
          lx_q  <= rdx;
          ly_q  <= rdy;
          rvx_q <= rdx;
          rvy_q <= rdy;
        end
      end
      S_RDPV: begin
        v1x_q <= sat35(35'(px_q) - 35'(rdx));
        v1y_q <= sat35(35'(py_q) - 35'(rdy));
      end
      S_RDNX: begin
        v2x_q <= sat35(35'(rdx) - 35'(px_q));
        v2y_q <= sat35(35'(rdy) - 35'(py_q));
      end
      S_M2, S_M5, S_M12: sq_q <= p_q;
      S_W1: if (unit_rsp.done) sum_q <= 33'(unit_rsp.result[31:0]);
      S_W2: if (unit_rsp.done) sum_q <= sum_q + 33'(unit_rsp.result[31:0]);
      S_M8: t_q <= 33'(wfull) + 33'd1;
      S_M10: begin
        width_q <= (wfull > 64'(width_cap_q)) ? '0 : wfull[30:0];
        ua_q    <= ua_s;
        ub_q    <= ub_s;
        a_neg_q <= a_v[34];
        b_neg_q <= b_v[34];
      end
      S_W3: begin
        if (unit_rsp.done) begin
          norm_q <= unit_rsp.result[31:0];
          ox_q   <= '0;
          oy_q   <= '0;
        end
      end
      S_W4, S_W5: if (unit_rsp.done) ux_q <= unit_rsp.result[16:0];
      S_M16: ox_q <= wfull[32:0];
      S_M18: oy_q <= wfull[32:0];
      S_FIN: begin
        lx_q  <= sat35(35'(px_q) + sox);
        ly_q  <= sat35(35'(py_q) + soy);
        rvx_q <= sat35(35'(px_q) - sox);
        rvy_q <= sat35(35'(py_q) - soy);
      end
      S_DONE: begin
        if (out_load) begin
          out_q.alive      <= live_q;
          out_q.start_slot <= 7'(tail_q);
          out_q.end_slot   <= 7'(head_q);
          out_q.age_left   <= age_q;
          out_q.owner_key  <= owner_q;
          out_q.left_x     <= lx_q;
          out_q.left_y     <= ly_q;
          out_q.right_x    <= rvx_q;
          out_q.right_y    <= rvy_q;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_live_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q |-> head_q != tail_q) else $error("live trail with empty span");
  a_dead_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !live_q |-> (head_q == '0 && tail_q == '0 && age_q == '0))
    else $error("dead trail state not cleared");
  a_first_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q |-> (valid_x_q[0] && valid_y_q[0])) else $error("first slot lost");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the trail ribbon vertex generator: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module tb_top import trvg_pkg::*; ();

  localparam int NPTS = TrailPointsDef;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 1500000;

  class ribbon_scoreboard;
    longint      px_ring[NPTS];
    longint      py_ring[NPTS];
    int          newest, oldest, age, gain, owner_id;
    bit          live;
    bit [11:0]   age_start_r, age_decay_r;
    bit [30:0]   width_cap_r;
    bit [22:0]   wide_gain_r, narrow_gain_r;
    trvg_out_t   pending_q[$];
    int          errors;

    function new();
      clear();
      age_start_r   = AGE_START_RST;
      age_decay_r   = AGE_DECAY_RST;
      width_cap_r   = WIDTH_CAP_RST;
      wide_gain_r   = WIDE_GAIN_RST;
      narrow_gain_r = NARROW_GAIN_RST;
      errors = 0;
    endfunction

    function void clear();
      foreach (px_ring[i]) begin
        px_ring[i] = 0;
        py_ring[i] = 0;
      end
      newest = 0; oldest = 0; age = 0; gain = 0; owner_id = 0; live = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_AGE_START:   age_start_r   = val[11:0];
        CFG_AGE_DECAY:   age_decay_r   = val[11:0];
        CFG_WIDTH_CAP:   width_cap_r   = val[30:0];
        CFG_WIDE_GAIN:   wide_gain_r   = val[22:0];
        CFG_NARROW_GAIN: narrow_gain_r = val[22:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
    endfunction

    function bit [63:0] root(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function bit [63:0] seg(longint dx, longint dy);
      bit [63:0] ax, ay;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      return root(ax * ax + ay * ay);
    endfunction

    function void ribbon(int s, output longint v[4]);
      int len, pos, prv, nxt;
      longint x, y, v1x, v1y, v2x, v2y, a, b, sox, soy;
      bit [63:0] sum, t, width, ua, ub, norm, ux, uy, ox, oy;
      v = '{0, 0, 0, 0};
      if (!live || s >= NPTS) return;
      len = (newest + NPTS - oldest) % NPTS;
      pos = (s + NPTS - oldest) % NPTS;
      if (len == 0 || pos > len) return;
      x = px_ring[s];
      y = py_ring[s];
      if (pos == 0 || pos == len) begin
        v = '{x, y, x, y};
        return;
      end
      prv = (s + NPTS - 1) % NPTS;
      nxt = (s + 1) % NPTS;
      v1x = clip(x - px_ring[prv]);
      v1y = clip(y - py_ring[prv]);
      v2x = clip(px_ring[nxt] - x);
      v2y = clip(py_ring[nxt] - y);
      sum = seg(v1x, v1y) + seg(v2x, v2y);
      t = 1 + ((sum * 26214 + 32768) >> 16);
      width = (t * gain + 32768) >> 16;
      if (width > width_cap_r) width = 0;
      a = 2 * v1y + v2y;
      b = -(2 * v1x + v2x);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      while (ua >= 64'h8000_0000 || ub >= 64'h8000_0000) begin
        ua >>= 1;
        ub >>= 1;
      end
      norm = root(ua * ua + ub * ub);
      if (norm == 0) begin
        ox = 0;
        oy = 0;
      end else begin
        ux = ((ua << 16) + norm / 2) / norm;
        uy = ((ub << 16) + norm / 2) / norm;
        ox = (ux * width + 32768) >> 16;
        oy = (uy * width + 32768) >> 16;
      end
      sox = a < 0 ? -longint'(ox) : longint'(ox);
      soy = b < 0 ? -longint'(oy) : longint'(oy);
      v = '{clip(x + sox), clip(y + soy), clip(x - sox), clip(y - soy)};
    endfunction

    function void note_item(trvg_in_t d);
      trvg_out_t e;
      longint v[4];
      v = '{0, 0, 0, 0};
      case (d.op)
        OP_APPEND: begin
          if (!live) begin
            clear();
            px_ring[0] = longint'(d.pos_x);
            py_ring[0] = longint'(d.pos_y);
            owner_id = int'(d.player_key);
            live = 1;
          end
          newest = (newest + 1) % NPTS;
          if (oldest == newest) oldest = (oldest + 1) % NPTS;
          px_ring[newest] = clip(longint'(d.pos_x) - longint'(d.offset_x));
          py_ring[newest] = clip(longint'(d.pos_y) - longint'(d.offset_y));
          age = int'(age_start_r);
          gain = int'(d.wide_trail ? wide_gain_r : narrow_gain_r);
        end
        OP_TICK: begin
          if (live) begin
            if (age < int'(age_decay_r)) clear();
            else age -= int'(age_decay_r);
          end
        end
        OP_SHIFT: begin
          if (live) begin
            foreach (px_ring[i]) px_ring[i] = clip(px_ring[i] + longint'(d.shift_x));
          end
        end
        default: ribbon(int'(d.slot), v);
      endcase
      e.alive = live;
      e.start_slot = 7'(oldest);
      e.end_slot = 7'(newest);
      e.age_left = 12'(age);
      e.owner_key = 3'(owner_id);
      e.left_x = 32'(v[0]);
      e.left_y = 32'(v[1]);
      e.right_x = 32'(v[2]);
      e.right_y = 32'(v[3]);
      pending_q.insert(pending_q.size(), e);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(trvg_out_t a);
      trvg_out_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %p", $time, a);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      cmp("alive", e.alive, a.alive);
      cmp("start_slot", e.start_slot, a.start_slot);
      cmp("end_slot", e.end_slot, a.end_slot);
      cmp("age_left", e.age_left, a.age_left);
      cmp("owner_key", e.owner_key, a.owner_key);
      cmp("left_x", e.left_x, a.left_x);
      cmp("left_y", e.left_y, a.left_y);
      cmp("right_x", e.right_x, a.right_x);
      cmp("right_y", e.right_y, a.right_y);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  bit   hold_req = 1'b0;

  trvg_cfg_if cfg_ch ();
  trvg_in_if  in_ch ();
  trvg_out_if out_ch ();

  ribbon_scoreboard sb = new();

  trail_ribbon_vertex_generator_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_item(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  // The receiver stalls on its own pattern, with one long hold-off on request.
  initial begin
    int mode;
    int run;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      run = $urandom_range(1, 40);
      repeat (run) begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 4) == 0);
          default: out_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic send_item(trvg_in_t d);
    in_ch.valid <= 1'b1;
    in_ch.data <= d;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic pause(int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    pause(1);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
    endcase
  endfunction

  function automatic trvg_in_t make_item(trvg_in_t base, logic [1:0] op, int s);
    trvg_in_t d;
    d = base;
    d.op = op;
    d.slot = 7'(s);
    return d;
  endfunction

  function automatic trvg_in_t random_item();
    trvg_in_t d;
    int r, len;
    d.pos_x = coord();
    d.pos_y = coord();
    d.offset_x = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'h3ffff) - 32'h20000;
    d.offset_y = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'h3ffff) - 32'h20000;
    d.wide_trail = 1'($urandom_range(0, 1));
    d.player_key = 3'($urandom_range(0, 7));
    d.shift_x = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h1ffff) - 32'h10000;
    r = $urandom_range(0, 99);
    d.op = r < 42 ? OP_APPEND : (r < 85 ? OP_READ : (r < 93 ? OP_TICK : OP_SHIFT));
    len = (sb.newest + NPTS - sb.oldest) % NPTS;
    if ($urandom_range(0, 4) == 0) d.slot = 7'($urandom_range(0, 127));
    else d.slot = 7'((sb.oldest + $urandom_range(0, len)) % NPTS);
    return d;
  endfunction

  task automatic random_phase(int count, bit squeeze);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (squeeze && sent == count / 2) hold_req = 1'b1;
        send_item(random_item());
        sent++;
      end
      pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
    end
    drain();
  endtask

  initial begin
    trvg_in_t b;
    logic [31:0] cfg_set[3][5];
    cfg_set[0] = '{32'd4095, 32'd1, 32'h7fff_ffff, 32'd4194304, 32'd4194304};
    cfg_set[1] = '{32'd40, 32'd20, 32'd0, 32'd0, 32'd0};
    cfg_set[2] = '{32'd1, 32'd4095, 32'd1000000, 32'd300000, 32'd65536};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    b = '0;
    b.player_key = 3'd5;
    b.wide_trail = 1'b1;
    send_item(make_item(b, OP_READ, 0));
    send_item(make_item(b, OP_TICK, 0));
    send_item(make_item(b, OP_SHIFT, 0));
    b.pos_x = 32'h7fff_ffff;
    b.pos_y = 32'h8000_0000;
    b.offset_x = 32'h8000_0000;
    b.offset_y = 32'h7fff_ffff;
    send_item(make_item(b, OP_APPEND, 0));
    b.pos_x = 32'h0001_0000;
    b.pos_y = 32'h0002_0000;
    b.offset_x = 32'h0;
    b.offset_y = 32'h0;
    b.player_key = 3'd2;
    send_item(make_item(b, OP_APPEND, 0));
    send_item(make_item(b, OP_APPEND, 0));
    send_item(make_item(b, OP_APPEND, 0));
    b.pos_x = 32'h0003_0000;
    send_item(make_item(b, OP_APPEND, 0));
    send_item(make_item(b, OP_READ, 0));
    send_item(make_item(b, OP_READ, 1));
    send_item(make_item(b, OP_READ, 2));
    send_item(make_item(b, OP_READ, 3));
    send_item(make_item(b, OP_READ, 4));
    send_item(make_item(b, OP_READ, 5));
    send_item(make_item(b, OP_READ, 127));
    b.shift_x = 32'h7fff_ffff;
    send_item(make_item(b, OP_SHIFT, 0));
    send_item(make_item(b, OP_READ, 1));
    b.shift_x = 32'h8000_0000;
    send_item(make_item(b, OP_SHIFT, 0));
    send_item(make_item(b, OP_READ, 3));
    send_item(make_item(b, OP_TICK, 0));
    drain();

    random_phase(150, 1'b0);
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 5; k++) write_cfg(3'(k), cfg_set[p][k]);
      if (p == 1) write_cfg(3'd5, $urandom());
      cfg_ch.valid <= 1'b0;
      random_phase(150, p == 0);
    end

    if (sb.pending_q.size() == 0 && sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
